@@ src/ship_streaming_rrip_replacement_core_defines.svh @@
// assertion macros for the replacement core checker
// expects a clock named clk and a reset named rst in the using scope
`ifndef SHIP_STREAMING_RRIP_REPLACEMENT_CORE_DEFINES_SVH
`define SHIP_STREAMING_RRIP_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication
`define SHIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ship_pkg.sv @@
// shared constants, types and helper functions of the replacement core
// no dependencies
`default_nettype none
package ship_pkg;
  localparam int NUM_SETS = 2048;
  localparam int NUM_WAYS = 16;
  localparam int SIG_BITS = 6;
  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int LOW_SET_BITS = 6;
  localparam int TAB_W = SIG_BITS + LOW_SET_BITS;
  localparam int TAB_SIZE = 1 << TAB_W;
  localparam int ADDR_W = 48;
  localparam int STRIDE_W = ADDR_W + 1;
  localparam int CLR_DEPTH = (TAB_SIZE > NUM_SETS) ? TAB_SIZE : NUM_SETS;
  localparam int CLR_W = $clog2(CLR_DEPTH);
  localparam logic [1:0] RRPV_MAX = 2'd3;
  localparam logic [1:0] REUSE_INIT = 2'd1;
  localparam logic [1:0] CNT_MAX = 2'd3;
  localparam logic [1:0] THR_INIT = 2'd2;

  typedef enum logic {
    CFG_STREAM = 1'b0,
    CFG_REUSE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_TAB
  } state_t;

  typedef struct packed {
    logic             clear;
    logic [CLR_W-1:0] clr_addr;
    logic             accept;
    logic             row_phase;
    logic             tab_phase;
    logic             busy;
  } ctl_t;

  typedef struct packed {
    logic [1:0]                         scnt;
    logic [STRIDE_W-1:0]                pstride;
    logic [ADDR_W-1:0]                  paddr;
    logic [NUM_WAYS-1:0][SIG_BITS-1:0]  sig;
    logic [NUM_WAYS-1:0][1:0]           rrpv;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  function automatic logic [SIG_BITS-1:0] make_sig(input logic [ADDR_W-1:0] pc);
    logic [ADDR_W-1:0] m;
    m = pc ^ (pc >> 6) ^ (pc >> 12);
    return m[SIG_BITS-1:0];
  endfunction

  function automatic logic [TAB_W-1:0] tab_idx(input logic [SIG_BITS-1:0] sig,
                                               input logic [SET_W-1:0] set);
    return {sig, set[LOW_SET_BITS-1:0]};
  endfunction
endpackage
`default_nettype wire

@@ src/ship_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none
module ship_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/ship_ctrl.sv @@
// sequencer: clearing pass after reset, then idle / row / table phases
// depends on ship_pkg
`default_nettype none
module ship_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          req_upd,
  output ship_pkg::ctl_t     ctl
);
  ship_pkg::state_t state, state_next;
  logic [ship_pkg::CLR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ship_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ship_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ship_pkg::ST_CLEAR: begin
        if (clr_cnt == ship_pkg::CLR_W'(ship_pkg::CLR_DEPTH - 1)) begin
          state_next = ship_pkg::ST_IDLE;
        end
      end
      ship_pkg::ST_IDLE: begin
        if (start) begin
          state_next = ship_pkg::ST_ROW;
        end
      end
      ship_pkg::ST_ROW: begin
        state_next = req_upd ? ship_pkg::ST_TAB : ship_pkg::ST_IDLE;
      end
      ship_pkg::ST_TAB: state_next = ship_pkg::ST_IDLE;
      default: state_next = ship_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.clear     = (state == ship_pkg::ST_CLEAR);
    ctl.clr_addr  = clr_cnt;
    ctl.accept    = (state == ship_pkg::ST_IDLE) && start;
    ctl.row_phase = (state == ship_pkg::ST_ROW);
    ctl.tab_phase = (state == ship_pkg::ST_TAB);
    ctl.busy      = (state != ship_pkg::ST_IDLE);
  end
endmodule
`default_nettype wire

@@ src/ship_streaming_rrip_replacement_core.sv @@
// rrip replacement with signature reuse counters and per-set stride detection
// a victim request result is registered out of the row phase, an update result
// out of the table phase; a new request is accepted only back in idle, once the
// read-modify-write of the set row memory, and for an update the counter memory, ends
// reset: a clearing pass over 4096 addresses (busy high) initializes both memories
// results come out on a one-cycle done strobe; the receiver cannot stall
`default_nettype none
module ship_streaming_rrip_replacement_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [10:0] set_index,
  input  wire logic [3:0]  way,
  input  wire logic [47:0] phys_addr,
  input  wire logic [47:0] prog_counter,
  input  wire logic        is_hit,
  output logic             done,
  output logic [3:0]       victim_way,
  output logic             streaming_seen,
  output logic [1:0]       new_rrpv,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data
);
  ship_pkg::ctl_t ctl;

  logic                            req_r;
  logic [ship_pkg::SET_W-1:0]      set_r;
  logic [ship_pkg::WAY_W-1:0]      way_r;
  logic [ship_pkg::ADDR_W-1:0]     addr_r;
  logic [ship_pkg::SIG_BITS-1:0]   sig_r;
  logic                            hit_r;
  logic [1:0]                      stream_thr;
  logic [1:0]                      reuse_thr;

  logic [ship_pkg::ROW_W-1:0]      row_rdata;
  logic [ship_pkg::ROW_W-1:0]      row_wdata;
  logic [ship_pkg::SET_W-1:0]      row_waddr;
  logic                            row_we;
  ship_pkg::row_t                  rd, aged, upd_row, row_r, fin_row, clr_row;

  logic [1:0]                      top_v, age;
  logic [ship_pkg::WAY_W-1:0]      vic;
  logic [ship_pkg::STRIDE_W-1:0]   stride;
  logic [1:0]                      cnt_new;
  logic                            streaming, strm_r;
  logic [ship_pkg::TAB_W-1:0]      idx_c, eidx_c, idx_r, eidx_r;

  logic [1:0]                      rc_a, rc_b, rc_dec, rc_cur, rc_wdata, nr;
  logic [ship_pkg::TAB_W-1:0]      rc_waddr;
  logic                            rc_we;

  assign busy      = ctl.busy;
  assign cfg_ready = 1'b1;

  ship_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_upd (req_r),
    .ctl     (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_thr <= ship_pkg::THR_INIT;
      reuse_thr  <= ship_pkg::THR_INIT;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ship_pkg::CFG_STREAM) begin
        stream_thr <= cfg_data;
      end else begin
        reuse_thr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_r  <= req_type;
      set_r  <= set_index[ship_pkg::SET_W-1:0];
      way_r  <= way[ship_pkg::WAY_W-1:0];
      addr_r <= phys_addr;
      sig_r  <= ship_pkg::make_sig(prog_counter);
      hit_r  <= is_hit;
    end
  end

  ship_ram #(.WIDTH(ship_pkg::ROW_W), .DEPTH(ship_pkg::NUM_SETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (set_index[ship_pkg::SET_W-1:0]),
    .rdata (row_rdata)
  );

  // row phase: victim search, aging and stride update
  always_comb begin
    rd    = ship_pkg::row_t'(row_rdata);
    top_v = '0;
    for (int w = 0; w < ship_pkg::NUM_WAYS; w++) begin
      if (rd.rrpv[w] > top_v) top_v = rd.rrpv[w];
    end
    age  = ship_pkg::RRPV_MAX - top_v;
    vic  = '0;
    aged = rd;
    for (int w = ship_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      aged.rrpv[w] = rd.rrpv[w] + age;
      if (rd.rrpv[w] == top_v) vic = ship_pkg::WAY_W'(w);
    end
    stride = {1'b0, addr_r} - {1'b0, rd.paddr};
    if ((rd.pstride != '0) && (stride == rd.pstride)) begin
      cnt_new = (rd.scnt == ship_pkg::CNT_MAX) ? rd.scnt : rd.scnt + 1'b1;
    end else begin
      cnt_new = (rd.scnt == 2'd0) ? rd.scnt : rd.scnt - 1'b1;
    end
    streaming       = (cnt_new >= stream_thr);
    upd_row         = rd;
    upd_row.scnt    = cnt_new;
    upd_row.pstride = stride;
    upd_row.paddr   = addr_r;
    idx_c  = ship_pkg::tab_idx(sig_r, set_r);
    eidx_c = ship_pkg::tab_idx(rd.sig[way_r], set_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.row_phase) begin
      row_r  <= upd_row;
      strm_r <= streaming;
      idx_r  <= idx_c;
      eidx_r <= eidx_c;
    end
  end

  // two copies of the counter table so current and evicted entries read together
  ship_ram #(.WIDTH(2), .DEPTH(ship_pkg::TAB_SIZE)) u_rc_cur (
    .clk   (clk),
    .we    (rc_we),
    .waddr (rc_waddr),
    .wdata (rc_wdata),
    .raddr (idx_c),
    .rdata (rc_a)
  );

  ship_ram #(.WIDTH(2), .DEPTH(ship_pkg::TAB_SIZE)) u_rc_evict (
    .clk   (clk),
    .we    (rc_we),
    .waddr (rc_waddr),
    .wdata (rc_wdata),
    .raddr (eidx_c),
    .rdata (rc_b)
  );

  // table phase: counter update and insertion decision
  always_comb begin
    rc_dec = (rc_b == 2'd0) ? rc_b : rc_b - 1'b1;
    rc_cur = (eidx_r == idx_r) ? rc_dec : rc_a;
    if (hit_r) begin
      nr = 2'd0;
    end else if (!strm_r && (rc_cur >= reuse_thr)) begin
      nr = 2'd0;
    end else begin
      nr = ship_pkg::RRPV_MAX;
    end
    fin_row              = row_r;
    fin_row.rrpv[way_r]  = nr;
    if (!hit_r) fin_row.sig[way_r] = sig_r;
  end

  always_comb begin
    clr_row = '0;
    for (int w = 0; w < ship_pkg::NUM_WAYS; w++) begin
      clr_row.rrpv[w] = ship_pkg::RRPV_MAX;
    end
    row_we    = 1'b0;
    row_waddr = set_r;
    row_wdata = fin_row;
    rc_we     = 1'b0;
    rc_waddr  = hit_r ? idx_r : eidx_r;
    rc_wdata  = hit_r ? ((rc_a == ship_pkg::CNT_MAX) ? rc_a : rc_a + 1'b1) : rc_dec;
    if (ctl.clear) begin
      row_we    = ({1'b0, ctl.clr_addr} < (ship_pkg::CLR_W + 1)'(ship_pkg::NUM_SETS));
      row_waddr = ctl.clr_addr[ship_pkg::SET_W-1:0];
      row_wdata = clr_row;
      rc_we     = ({1'b0, ctl.clr_addr} < (ship_pkg::CLR_W + 1)'(ship_pkg::TAB_SIZE));
      rc_waddr  = ctl.clr_addr[ship_pkg::TAB_W-1:0];
      rc_wdata  = ship_pkg::REUSE_INIT;
    end else if (ctl.row_phase && !req_r) begin
      row_we    = 1'b1;
      row_wdata = aged;
    end else if (ctl.tab_phase) begin
      row_we = 1'b1;
      rc_we  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctl.row_phase && !req_r) || ctl.tab_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.row_phase && !req_r) begin
      victim_way     <= 4'(vic);
      streaming_seen <= 1'b0;
      new_rrpv       <= 2'd0;
    end else if (ctl.tab_phase) begin
      victim_way     <= 4'd0;
      streaming_seen <= strm_r;
      new_rrpv       <= nr;
    end
  end
endmodule
`default_nettype wire

@@ src/ship_checker.sv @@
// port-level checks of the replacement core, bound to the top level
// depends on ship_streaming_rrip_replacement_core_defines.svh
`default_nettype none
`include "ship_streaming_rrip_replacement_core_defines.svh"
module ship_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [3:0] victim_way,
  input wire logic       streaming_seen,
  input wire logic [1:0] new_rrpv
);
  // a word comes out only once the sequencer is back to idle
  `SHIP_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
  `SHIP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
  `SHIP_ASSERT_NEXT(a_no_early, start && !busy, !done, "result one cycle after accept")
  // a nonzero victim way only comes from a victim request
  `SHIP_ASSERT_NOW(a_victim_clean, done && (victim_way != 4'd0),
                   !streaming_seen && (new_rrpv == 2'd0), "victim word has update fields")
endmodule

bind ship_streaming_rrip_replacement_core ship_checker u_ship_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .victim_way     (victim_way),
  .streaming_seen (streaming_seen),
  .new_rrpv       (new_rrpv)
);
`default_nettype wire
